// File: sv/masked_sprite_row_compositor_assert.svh
// ----------------------------------------------------------------------------
// masked sprite row compositor assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MASKED_SPRITE_ROW_COMPOSITOR_ASSERT_SVH
`define MASKED_SPRITE_ROW_COMPOSITOR_ASSERT_SVH

// same-cycle implication, off while reset is active
`define MSRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is active
`define MSRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/msrc_pkg.sv
// ----------------------------------------------------------------------------
// msrc_pkg
// types, constants and helpers of the masked sprite row compositor
// ----------------------------------------------------------------------------
package msrc_pkg;

	localparam int BUF_BYTES  = 72;
	localparam int ADDR_W     = 7;
	// buffer split on address bit 3 into two banks of 8-byte groups
	localparam int BANK_DEPTH = ((BUF_BYTES + 15) / 16) * 8;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);

	typedef logic [7:0] pix_byte_t;
	typedef logic [ADDR_W-1:0] buf_addr_t;
	typedef logic [BANK_AW-1:0] bank_idx_t;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_BLEND = 2'd2
	} func_t;

	function automatic logic [5:0] tile_base(input logic [1:0] tile);
		logic [5:0] base;
		case (tile)
			2'd0: base = 6'd0;
			2'd1: base = 6'd8;
			2'd2: base = 6'd24;
			2'd3: base = 6'd32;
			default: base = 6'd0;
		endcase
		return base;
	endfunction

	function automatic pix_byte_t rev8(input pix_byte_t b);
		pix_byte_t r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	// drop bit 3 (the bank select) to get the row inside a bank
	function automatic bank_idx_t bank_idx(input buf_addr_t a);
		return bank_idx_t'({a[6:4], a[2:0]});
	endfunction

endpackage

// File: sv/masked_sprite_row_compositor.sv
// ----------------------------------------------------------------------------
// masked_sprite_row_compositor
// The block keeps a 72-byte sprite buffer (3 by 3 cells of 8 rows, 24-byte
// stride) and takes one transaction per clock unless stalled: write a byte,
// read a byte, or blend one masked, optionally flipped, shifted sprite row
// into two bytes. A result is registered in stage 1 and then in the output
// register; the input stalls only while a finished result waits on a stalled
// output. The buffer lives in two rams split on address bit 3, so the two
// bytes of a blend, 8 apart, always fall in different banks; each bank does
// one read at accept and one write when the transaction leaves stage 1, with
// a bypass of the last write, and that read-modify-write per bank is what
// holds the rate at one per cycle unless stalled. Per-entry valid bits make
// the buffer read as zero right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module masked_sprite_row_compositor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [6:0] buf_addr,
	input  logic [7:0] buf_data,
	input  logic [1:0] tile_num,
	input  logic [2:0] row_num,
	input  logic [7:0] texture_byte,
	input  logic [7:0] mask_byte,
	input  logic       flip_h,
	input  logic [2:0] shift_h,
	input  logic [2:0] shift_v,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data
);

	localparam int NUM_BANKS = 2;

	logic accept;
	logic adv;
	msrc_pkg::func_t func_in;
	logic [3:0] row_sum;
	msrc_pkg::buf_addr_t dst_l;
	msrc_pkg::buf_addr_t dst_r;
	logic in_range;
	msrc_pkg::buf_addr_t bank_addr [NUM_BANKS];
	logic re [NUM_BANKS];

	logic valid_s1;
	msrc_pkg::func_t func_s1;
	logic in_range_s1;
	logic bank_sel_s1;
	logic left_bank_s1;
	msrc_pkg::bank_idx_t idx_s1 [NUM_BANKS];
	msrc_pkg::pix_byte_t data_s1;
	msrc_pkg::pix_byte_t tex_s1;
	msrc_pkg::pix_byte_t msk_s1;
	logic flip_s1;
	logic [2:0] sh_s1;

	msrc_pkg::pix_byte_t rd_data [NUM_BANKS];
	msrc_pkg::pix_byte_t old_byte [NUM_BANKS];
	msrc_pkg::pix_byte_t wdata [NUM_BANKS];
	logic we [NUM_BANKS];
	msrc_pkg::pix_byte_t tex_f;
	msrc_pkg::pix_byte_t msk_f;
	logic [15:0] tex_split;
	logic [15:0] msk_split;
	msrc_pkg::pix_byte_t result;

	logic valid_q [NUM_BANKS][msrc_pkg::BANK_DEPTH];
	logic fwd_en_q [NUM_BANKS];
	msrc_pkg::bank_idx_t fwd_idx_q [NUM_BANKS];
	msrc_pkg::pix_byte_t fwd_data_q [NUM_BANKS];

	logic out_valid_q;
	msrc_pkg::pix_byte_t read_data_q;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// input side: blend destination and bank read addresses
	always_comb begin
		func_in  = msrc_pkg::func_t'(func);
		row_sum  = {1'b0, row_num} + {1'b0, shift_v};
		dst_l    = msrc_pkg::buf_addr_t'(shift_v) + msrc_pkg::buf_addr_t'(row_num)
			+ msrc_pkg::buf_addr_t'(msrc_pkg::tile_base(tile_num))
			+ (row_sum[3] ? 7'd16 : 7'd0);
		dst_r    = dst_l + 7'd8;
		in_range = buf_addr < 7'(msrc_pkg::BUF_BYTES);
		for (int b = 0; b < NUM_BANKS; b++) begin
			if (func_in == msrc_pkg::FUNC_BLEND) begin
				bank_addr[b] = (dst_l[3] == 1'(b)) ? dst_l : dst_r;
			end else begin
				bank_addr[b] = buf_addr;
			end
			re[b] = accept && ((func_in == msrc_pkg::FUNC_BLEND)
				|| ((func_in == msrc_pkg::FUNC_READ) && in_range && (buf_addr[3] == 1'(b))));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1      <= func_in;
			in_range_s1  <= in_range;
			bank_sel_s1  <= buf_addr[3];
			left_bank_s1 <= dst_l[3];
			data_s1      <= buf_data;
			tex_s1       <= texture_byte;
			msk_s1       <= mask_byte;
			flip_s1      <= flip_h;
			sh_s1        <= shift_h;
			for (int b = 0; b < NUM_BANKS; b++) begin
				idx_s1[b] <= msrc_pkg::bank_idx(bank_addr[b]);
			end
		end
	end

	// stage 1: merge against the old bytes or take the write byte, write back, and form the read result
	always_comb begin
		tex_f     = flip_s1 ? msrc_pkg::rev8(tex_s1) : tex_s1;
		msk_f     = flip_s1 ? msrc_pkg::rev8(msk_s1) : msk_s1;
		// high byte is the left part, low byte the right part
		tex_split = {tex_f, 8'h00} >> sh_s1;
		msk_split = {msk_f, 8'h00} >> sh_s1;
		for (int b = 0; b < NUM_BANKS; b++) begin
			if (!valid_q[b][idx_s1[b]]) begin
				old_byte[b] = 8'h00;
			end else if (fwd_en_q[b] && (fwd_idx_q[b] == idx_s1[b])) begin
				old_byte[b] = fwd_data_q[b];
			end else begin
				old_byte[b] = rd_data[b];
			end
			if (func_s1 == msrc_pkg::FUNC_BLEND) begin
				if (left_bank_s1 == 1'(b)) begin
					wdata[b] = (old_byte[b] & ~msk_split[15:8]) | tex_split[15:8];
				end else begin
					wdata[b] = (old_byte[b] & ~msk_split[7:0]) | tex_split[7:0];
				end
			end else begin
				wdata[b] = data_s1;
			end
			we[b] = adv && ((func_s1 == msrc_pkg::FUNC_BLEND)
				|| ((func_s1 == msrc_pkg::FUNC_WRITE) && in_range_s1
				&& (bank_sel_s1 == 1'(b))));
		end
		if ((func_s1 == msrc_pkg::FUNC_READ) && in_range_s1) begin
			result = old_byte[bank_sel_s1];
		end else begin
			result = 8'h00;
		end
	end

	for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
		msrc_ram #(
			.WIDTH(8),
			.DEPTH(msrc_pkg::BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we[g]),
			.waddr(idx_s1[g]),
			.wdata(wdata[g]),
			.re   (re[g]),
			.raddr(msrc_pkg::bank_idx(bank_addr[g])),
			.rdata(rd_data[g])
		);
	end

	// valid bits and last-write bypass per bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANKS; b++) begin
				fwd_en_q[b] <= 1'b0;
				for (int i = 0; i < msrc_pkg::BANK_DEPTH; i++) begin
					valid_q[b][i] <= 1'b0;
				end
			end
		end else begin
			for (int b = 0; b < NUM_BANKS; b++) begin
				if (we[b]) begin
					fwd_en_q[b]           <= 1'b1;
					valid_q[b][idx_s1[b]] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			if (we[b]) begin
				fwd_idx_q[b]  <= idx_s1[b];
				fwd_data_q[b] <= wdata[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

// File: sv/msrc_ram.sv
// ----------------------------------------------------------------------------
// msrc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module msrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = msrc_pkg::BANK_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/msrc_checker.sv
// ----------------------------------------------------------------------------
// msrc_port_checker
// port-level checks of the masked sprite row compositor, bound to the top
// ----------------------------------------------------------------------------
`include "masked_sprite_row_compositor_assert.svh"

module msrc_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data
);

	// input backs up only behind a blocked result
	`MSRC_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "input stalled without a blocked result")

	// a fresh result needs an earlier accepted transaction, passed through stage 1 and the output register
	`MSRC_ASSERT_IMP(a_result_latency, clk, arst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without matching input")

	`MSRC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_data), "stalled result changed")

endmodule

bind masked_sprite_row_compositor msrc_port_checker u_msrc_checker (.*);
